@@ hdl/bencode_stream_tokenizer_unit_defines.svh @@
// Assertion macros shared by the bencode tokenizer RTL.
`ifndef BENCODE_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`define BENCODE_STREAM_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bencode tokenizer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bencode tokenizer: next-cycle check failed");

`endif

@@ hdl/bst_pkg.sv @@
// Package: constants, codes and types of the bencode stream tokenizer.
package bst_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int STACK_AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SP_W      = $clog2(MAX_DEPTH + 1);
    localparam int NEST_W    = 6;

    // Stack entry bits
    localparam logic [1:0] K_LIST      = 2'b00;
    localparam logic [1:0] K_DICT_KEY  = 2'b11;

    // Event kinds
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_INT       = 3'd1;
    localparam logic [2:0] EV_STR_START = 3'd2;
    localparam logic [2:0] EV_STR_BYTE  = 3'd3;
    localparam logic [2:0] EV_LIST_OPEN = 3'd4;
    localparam logic [2:0] EV_DICT_OPEN = 3'd5;
    localparam logic [2:0] EV_CLOSE     = 3'd6;
    localparam logic [2:0] EV_ERROR     = 3'd7;

    // Error codes
    localparam logic [4:0] ERR_NONE         = 5'd0;
    localparam logic [4:0] ERR_EARLY_END    = 5'd1;
    localparam logic [4:0] ERR_BAD_CHAR     = 5'd2;
    localparam logic [4:0] ERR_INT_UNTERM   = 5'd3;
    localparam logic [4:0] ERR_INT_EMPTY    = 5'd4;
    localparam logic [4:0] ERR_NEG_ZERO     = 5'd5;
    localparam logic [4:0] ERR_LEAD_ZERO    = 5'd6;
    localparam logic [4:0] ERR_NEG_LEAD_ZERO= 5'd7;
    localparam logic [4:0] ERR_INT_BAD      = 5'd8;
    localparam logic [4:0] ERR_NO_COLON     = 5'd9;
    localparam logic [4:0] ERR_STR_PAST_END = 5'd10;
    localparam logic [4:0] ERR_KEY_NOT_STR  = 5'd11;
    localparam logic [4:0] ERR_LIST_UNTERM  = 5'd12;
    localparam logic [4:0] ERR_DICT_UNTERM  = 5'd13;
    localparam logic [4:0] ERR_TRAILING     = 5'd14;
    localparam logic [4:0] ERR_TOO_DEEP     = 5'd15;
    localparam logic [4:0] ERR_LEN_TOO_BIG  = 5'd16;

    // Pending integer fault codes kept in the digit counter
    localparam logic [3:0] DC_LEAD_ZERO     = 4'd6;
    localparam logic [3:0] DC_NEG_LEAD_ZERO = 4'd7;
    localparam logic [3:0] DC_BAD           = 4'd8;

    // Character constants
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [63:0] num;
        logic [7:0]        cbyte;
        logic [NEST_W-1:0] depth;
        logic              key;
        logic [4:0]        err;
        logic              ok;
    } event_t;

endpackage

@@ hdl/bencode_stream_tokenizer_unit.sv @@
// Top level: streaming bencode tokenizer, one event per accepted item.
//
// Usage:
//   Input channel (item_valid / item_stall) carries byte_value, byte_present
//   and end_of_data. Each accepted item yields exactly one event on the
//   output channel (event_valid / event_stall): kind, number, content byte,
//   nesting depth, key flag, latched error code and document_ok.
//   Throughput is one item per cycle while item_stall is low. An accepted
//   item's event is registered in the main output register or the skid entry.
//   The container stack lives in a synchronous-read RAM. The top entry is
//   held in a register and the entry below it is prefetched every cycle at
//   sp-2 (with forwarding of a push written that same cycle), so a close can
//   pop back to back with no bubble.
//   The output side is a main register plus one skid entry; item_stall is
//   the registered skid-full flag, so one more item is taken while a result
//   waits under stall, then input stalls until the receiver drains.
//   Reset (rst_n low, async) clears the parser to "expect top-level value",
//   empties the stack and output buffers and clears the latched error. The
//   stack RAM needs no clearing: entries are read only after being pushed.
//   Errors stick until reset: every later item gives an error event.
`include "bencode_stream_tokenizer_unit_defines.svh"

module bencode_stream_tokenizer_unit
    import bst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [7:0]          byte_value,
    input  logic                byte_present,
    input  logic                end_of_data,
    output logic                event_valid,
    input  logic                event_stall,
    output logic [2:0]          event_kind,
    output logic signed [63:0]  number_value,
    output logic [7:0]          content_byte,
    output logic [NEST_W-1:0]   nest_depth,
    output logic                is_key,
    output logic [4:0]          error_code,
    output logic                document_ok
);

    typedef enum logic [6:0] {
        M_EXPECT    = 7'b0000001,
        M_INT_START = 7'b0000010,
        M_INT_BODY  = 7'b0000100,
        M_INT_BAD   = 7'b0001000,
        M_STR_LEN   = 7'b0010000,
        M_STR_BODY  = 7'b0100000,
        M_DONE      = 7'b1000000
    } mode_t;

    localparam logic [67:0] LIM_POS  = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] LIM_NEG  = 68'h0_8000_0000_0000_0000;
    localparam logic [67:0] LEN_MAX  = 68'h0_0000_0000_FFFF_FFFF;
    localparam logic [63:0] LEN_SAT  = 64'h0000_0001_0000_0000;

    // Parser state
    mode_t           mode_reg,   mode_next;
    logic [63:0]     acc_reg,    acc_next;
    logic            neg_reg,    neg_next;
    logic [3:0]      dcount_reg, dcount_next;
    logic [31:0]     strrem_reg, strrem_next;
    logic [SP_W-1:0] sp_reg,     sp_next;
    logic [1:0]      top_reg,    top_next;
    logic [4:0]      err_reg,    err_next;

    // Stack RAM access
    logic                wen;
    logic [STACK_AW-1:0] waddr, raddr;
    logic [1:0]          wdata, rd_data, below;
    logic                fwd_valid_reg, fwd_valid_next;
    logic [1:0]          fwd_data_reg;
    logic [SP_W-1:0]     sp_upd;

    // Output buffer
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    event_t out_reg, out_next;
    event_t skid_reg, skid_next;
    event_t ev;

    logic        accept, take;
    logic        digit;
    logic [3:0]  dval;
    logic [67:0] madd;
    logic        push, pop, done_item;

    assign accept = item_valid && !skid_valid_reg;
    assign take   = out_valid_reg && !event_stall;

    assign digit = byte_value inside {[CH_ZERO:CH_NINE]};
    assign dval  = 4'(byte_value - CH_ZERO);
    // Shared x10 + digit unit for integers and string lengths
    assign madd  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + 68'(dval);

    // Entry just below the top of stack
    assign below = fwd_valid_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        dcount_next = dcount_reg;
        strrem_next = strrem_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        err_next    = err_reg;
        push        = 1'b0;
        pop         = 1'b0;
        done_item   = 1'b0;
        ev          = '0;
        ev.kind     = EV_NONE;

        // Byte phase
        if (err_reg == ERR_NONE && byte_present)
        begin
            case (mode_reg)
                M_DONE:
                begin
                    err_next = ERR_TRAILING;
                end
                M_EXPECT:
                begin
                    if (sp_reg != '0 && top_reg == K_DICT_KEY)
                    begin
                        if (byte_value == CH_E)
                        begin
                            pop = 1'b1;
                        end
                        else if (digit)
                        begin
                            acc_next  = 64'(dval);
                            mode_next = M_STR_LEN;
                        end
                        else
                        begin
                            err_next = ERR_KEY_NOT_STR;
                        end
                    end
                    else if (byte_value == CH_E && sp_reg != '0 && !top_reg[0])
                    begin
                        pop = 1'b1;
                    end
                    else if (byte_value == CH_I)
                    begin
                        mode_next = M_INT_START;
                    end
                    else if (byte_value == CH_L || byte_value == CH_D)
                    begin
                        if (sp_reg >= SP_W'(MAX_DEPTH))
                        begin
                            err_next = ERR_TOO_DEEP;
                        end
                        else
                        begin
                            push     = 1'b1;
                            sp_next  = sp_reg + 1'b1;
                            top_next = (byte_value == CH_D) ? K_DICT_KEY : K_LIST;
                            ev.kind  = (byte_value == CH_D) ? EV_DICT_OPEN : EV_LIST_OPEN;
                        end
                    end
                    else if (digit)
                    begin
                        acc_next  = 64'(dval);
                        mode_next = M_STR_LEN;
                    end
                    else
                    begin
                        err_next = ERR_BAD_CHAR;
                    end
                end
                M_INT_START:
                begin
                    acc_next    = '0;
                    neg_next    = 1'b0;
                    dcount_next = '0;
                    if (byte_value == CH_E)
                    begin
                        err_next = ERR_INT_EMPTY;
                    end
                    else if (byte_value == CH_MINUS)
                    begin
                        neg_next  = 1'b1;
                        mode_next = M_INT_BODY;
                    end
                    else if (digit)
                    begin
                        acc_next    = 64'(dval);
                        dcount_next = 4'd1;
                        mode_next   = M_INT_BODY;
                    end
                    else
                    begin
                        dcount_next = DC_BAD;
                        mode_next   = M_INT_BAD;
                    end
                end
                M_INT_BODY:
                begin
                    if (byte_value == CH_E)
                    begin
                        if (dcount_reg == '0)
                        begin
                            err_next = ERR_INT_BAD;
                        end
                        else if (neg_reg && acc_reg == '0)
                        begin
                            err_next = ERR_NEG_ZERO;
                        end
                        else
                        begin
                            ev.kind   = EV_INT;
                            ev.num    = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
                            done_item = 1'b1;
                        end
                    end
                    else if (dcount_reg == 4'd1 && acc_reg == '0)
                    begin
                        dcount_next = neg_reg ? DC_NEG_LEAD_ZERO : DC_LEAD_ZERO;
                        mode_next   = M_INT_BAD;
                    end
                    else if (digit)
                    begin
                        if (madd > (neg_reg ? LIM_NEG : LIM_POS))
                        begin
                            dcount_next = DC_BAD;
                            mode_next   = M_INT_BAD;
                        end
                        else
                        begin
                            acc_next = madd[63:0];
                            if (dcount_reg < 4'd2)
                            begin
                                dcount_next = dcount_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        dcount_next = DC_BAD;
                        mode_next   = M_INT_BAD;
                    end
                end
                M_INT_BAD:
                begin
                    if (byte_value == CH_E)
                    begin
                        err_next = 5'(dcount_reg);
                    end
                end
                M_STR_LEN:
                begin
                    if (digit)
                    begin
                        // Saturate once the length passes 32 bits
                        if ({4'b0000, acc_reg} <= LEN_MAX)
                        begin
                            acc_next = (madd > LEN_MAX) ? LEN_SAT : madd[63:0];
                        end
                    end
                    else if (byte_value == CH_COLON)
                    begin
                        if ({4'b0000, acc_reg} > LEN_MAX)
                        begin
                            err_next = ERR_LEN_TOO_BIG;
                        end
                        else
                        begin
                            ev.kind     = EV_STR_START;
                            ev.num      = $signed(acc_reg);
                            ev.key      = (sp_reg != '0 && top_reg == K_DICT_KEY);
                            strrem_next = acc_reg[31:0];
                            if (acc_reg[31:0] == '0)
                            begin
                                done_item = 1'b1;
                            end
                            else
                            begin
                                mode_next = M_STR_BODY;
                            end
                        end
                    end
                    else
                    begin
                        err_next = ERR_NO_COLON;
                    end
                end
                M_STR_BODY:
                begin
                    ev.kind     = EV_STR_BYTE;
                    ev.cbyte    = byte_value;
                    ev.key      = (sp_reg != '0 && top_reg == K_DICT_KEY);
                    strrem_next = strrem_reg - 1'b1;
                    if (strrem_reg == 32'd1)
                    begin
                        done_item = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_EXPECT;
                end
            endcase
        end

        // Close pops to the prefetched entry below the top
        if (pop)
        begin
            sp_next   = sp_reg - 1'b1;
            top_next  = below;
            ev.kind   = EV_CLOSE;
            done_item = 1'b1;
        end

        // Completed value: finish the document at top level, or toggle key/value on an enclosing dictionary
        if (done_item)
        begin
            if (sp_next == '0)
            begin
                mode_next = M_DONE;
            end
            else
            begin
                if (top_next[0])
                begin
                    top_next[1] = ~top_next[1];
                end
                mode_next = M_EXPECT;
            end
        end

        // End phase
        if (err_next == ERR_NONE && end_of_data)
        begin
            case (mode_next)
                M_DONE:
                begin
                    ev.ok = 1'b1;
                end
                M_EXPECT:
                begin
                    if (sp_next == '0)
                    begin
                        err_next = ERR_EARLY_END;
                    end
                    else if (top_next == K_DICT_KEY)
                    begin
                        err_next = ERR_DICT_UNTERM;
                    end
                    else if (top_next[0])
                    begin
                        err_next = ERR_EARLY_END;
                    end
                    else
                    begin
                        err_next = ERR_LIST_UNTERM;
                    end
                end
                M_STR_LEN:
                begin
                    err_next = ERR_NO_COLON;
                end
                M_STR_BODY:
                begin
                    err_next = ERR_STR_PAST_END;
                end
                default:
                begin
                    err_next = ERR_INT_UNTERM;
                end
            endcase
        end

        if (err_next != ERR_NONE)
        begin
            ev       = '0;
            ev.kind  = EV_ERROR;
        end
        ev.depth = NEST_W'(sp_next);
        ev.err   = err_next;
    end

    // Push saves the old top below the new one
    assign wen    = accept && push && (sp_reg != '0);
    assign waddr  = STACK_AW'(sp_reg - 1'b1);
    assign wdata  = top_reg;
    assign sp_upd = accept ? sp_next : sp_reg;
    assign raddr  = STACK_AW'(sp_upd - SP_W'(2));
    assign fwd_valid_next = wen && (waddr == raddr);

    bst_ram #(
        .WIDTH (2),
        .DEPTH (MAX_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wen),
        .wr_addr (waddr),
        .wr_data (wdata),
        .rd_addr (raddr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_EXPECT;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            dcount_reg    <= '0;
            strrem_reg    <= '0;
            sp_reg        <= '0;
            top_reg       <= K_LIST;
            err_reg       <= ERR_NONE;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
            if (accept)
            begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                neg_reg    <= neg_next;
                dcount_reg <= dcount_next;
                strrem_reg <= strrem_next;
                sp_reg     <= sp_next;
                top_reg    <= top_next;
                err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

    // Output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next = ev;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_next       = ev;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = ev;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign item_stall   = skid_valid_reg;
    assign event_valid  = out_valid_reg;
    assign event_kind   = out_reg.kind;
    assign number_value = out_reg.num;
    assign content_byte = out_reg.cbyte;
    assign nest_depth   = out_reg.depth;
    assign is_key       = out_reg.key;
    assign error_code   = out_reg.err;
    assign document_ok  = out_reg.ok;

    `BST_ASSERT_NOW(a_skid_implies_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `BST_ASSERT_NOW(a_sp_in_range, clk, rst_n, 1'b1, sp_reg <= SP_W'(MAX_DEPTH))
    `BST_ASSERT_NEXT(a_error_sticks, clk, rst_n, err_reg != ERR_NONE, err_reg == $past(err_reg))
    `BST_ASSERT_NOW(a_error_event_has_code, clk, rst_n, out_valid_reg && out_reg.kind == EV_ERROR, out_reg.err != ERR_NONE)

endmodule

@@ hdl/bst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bst_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a same-address read returns the old word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the streaming bencode tokenizer unit.
`timescale 1ns / 100ps

module tb_top;
    import bst_pkg::*;

    localparam int  HALF_PERIOD  = 10;
    localparam int  BYTE_TARGET  = 1000;   // bytes in the random body of the document
    localparam int  DRAIN_LIMIT  = 2000;   // cycles allowed for the last events to come out
    localparam int  SETTLE       = 10;     // extra cycles after the last event
    localparam time RUN_LIMIT    = 10ms;

    // Parser phases of the behavioral tokenizer below.
    typedef enum logic [2:0] {
        PH_VALUE,       // waiting for a value, a key or a close
        PH_INT_FIRST,   // just saw 'i'
        PH_INT_DIGITS,  // inside an integer, still well formed
        PH_INT_FAULT,   // malformed integer, fault code held until 'e'
        PH_LEN,         // reading a string length
        PH_CONTENT,     // reading string content
        PH_FINISHED     // top-level value complete
    } phase_e;

    // One row of the directed stimulus table. Rows with typed set carry
    // their expected event; the rest are checked against the tokenizer model.
    typedef struct {
        logic [7:0]         b;
        bit                 p;
        bit                 e;
        bit                 typed;
        logic [2:0]         kind;
        logic signed [63:0] num;
        logic [7:0]         cb;
        logic [5:0]         depth;
        bit                 key;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [7:0]         byte_value;
    logic               byte_present;
    logic               end_of_data;
    logic               event_valid;
    logic               event_stall;
    logic [2:0]         event_kind;
    logic signed [63:0] number_value;
    logic [7:0]         content_byte;
    logic [NEST_W-1:0]  nest_depth;
    logic               is_key;
    logic [4:0]         error_code;
    logic               document_ok;

    bencode_stream_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .byte_value   (byte_value),
        .byte_present (byte_present),
        .end_of_data  (end_of_data),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .number_value (number_value),
        .content_byte (content_byte),
        .nest_depth   (nest_depth),
        .is_key       (is_key),
        .error_code   (error_code),
        .document_ok  (document_ok)
    );

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    event_t     expected_events[$];   // events owed by the DUT, oldest first
    dir_row_t   dir_rows[$];
    int         n_mismatch;
    int         n_events;
    int         n_items;
    int         n_bytes;
    int         deepest;
    bit         quiet;                // stretch with no idling on either side
    logic [4:0] ending_case;

    // ------------------------------------------------------------------
    // Behavioral tokenizer: its own copy of the parse state
    // ------------------------------------------------------------------
    phase_e      phase;
    logic [63:0] acc;           // integer magnitude or string length
    logic        neg;
    logic [4:0]  dcount;        // digit count (sat. at 2) or pending fault code
    logic [31:0] str_left;
    logic [1:0]  nest_stack [MAX_DEPTH];   // bit0 dict, bit1 dict wants a key
    int unsigned sp;
    logic [4:0]  sticky_err;

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit key_wanted();
        return sp != 0 && nest_stack[sp-1] == K_DICT_KEY;
    endfunction

    task automatic raise_err(input logic [4:0] code);
        if (sticky_err == ERR_NONE)
            sticky_err = code;
    endtask

    // A value just finished: either the document is done, or a dict
    // alternates between key and value.
    task automatic value_done();
        if (sp == 0)
        begin
            phase = PH_FINISHED;
            return;
        end
        if (nest_stack[sp-1][0])
            nest_stack[sp-1][1] = ~nest_stack[sp-1][1];
        phase = PH_VALUE;
    endtask

    task automatic tokenize_step(input logic [7:0] b, input bit p, input bit e,
                                 output event_t ev);
        logic [63:0] lim;
        logic [63:0] d;
        bit          in_list;
        ev       = '0;
        ev.kind  = EV_NONE;
        d        = {56'd0, b - CH_ZERO};
        if (sticky_err == ERR_NONE && p)
        begin
            case (phase)
                PH_FINISHED:
                    raise_err(ERR_TRAILING);
                PH_VALUE:
                begin
                    in_list = sp != 0 && !nest_stack[sp-1][0];
                    if (key_wanted())
                    begin
                        if (b == CH_E)
                        begin
                            sp--;
                            ev.kind = EV_CLOSE;
                            value_done();
                        end
                        else if (is_digit(b))
                        begin
                            acc   = d;
                            phase = PH_LEN;
                        end
                        else
                            raise_err(ERR_KEY_NOT_STR);
                    end
                    else if (b == CH_E && in_list)
                    begin
                        sp--;
                        ev.kind = EV_CLOSE;
                        value_done();
                    end
                    else if (b == CH_I)
                        phase = PH_INT_FIRST;
                    else if (b == CH_L || b == CH_D)
                    begin
                        if (sp >= MAX_DEPTH)
                            raise_err(ERR_TOO_DEEP);
                        else
                        begin
                            nest_stack[sp] = (b == CH_D) ? K_DICT_KEY : K_LIST;
                            sp++;
                            ev.kind = (b == CH_D) ? EV_DICT_OPEN : EV_LIST_OPEN;
                        end
                    end
                    else if (is_digit(b))
                    begin
                        acc   = d;
                        phase = PH_LEN;
                    end
                    else
                        raise_err(ERR_BAD_CHAR);
                end
                PH_INT_FIRST:
                begin
                    acc    = '0;
                    neg    = 1'b0;
                    dcount = '0;
                    if (b == CH_E)
                        raise_err(ERR_INT_EMPTY);
                    else if (b == CH_MINUS)
                    begin
                        neg   = 1'b1;
                        phase = PH_INT_DIGITS;
                    end
                    else if (is_digit(b))
                    begin
                        acc    = d;
                        dcount = 5'd1;
                        phase  = PH_INT_DIGITS;
                    end
                    else
                    begin
                        dcount = {1'b0, DC_BAD};
                        phase  = PH_INT_FAULT;
                    end
                end
                PH_INT_DIGITS:
                begin
                    if (b == CH_E)
                    begin
                        if (dcount == 0)
                            raise_err(ERR_INT_BAD);
                        else if (neg && acc == 0)
                            raise_err(ERR_NEG_ZERO);
                        else
                        begin
                            ev.kind = EV_INT;
                            ev.num  = neg ? -acc : acc;
                            value_done();
                        end
                    end
                    else if (dcount == 1 && acc == 0)
                    begin
                        // anything after a lone leading zero is a fault
                        dcount = neg ? {1'b0, DC_NEG_LEAD_ZERO} : {1'b0, DC_LEAD_ZERO};
                        phase  = PH_INT_FAULT;
                    end
                    else if (is_digit(b))
                    begin
                        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                        if (acc > (lim - d) / 10)
                        begin
                            dcount = {1'b0, DC_BAD};
                            phase  = PH_INT_FAULT;
                        end
                        else
                        begin
                            acc = acc * 10 + d;
                            if (dcount < 2)
                                dcount++;
                        end
                    end
                    else
                    begin
                        dcount = {1'b0, DC_BAD};
                        phase  = PH_INT_FAULT;
                    end
                end
                PH_INT_FAULT:
                    if (b == CH_E)
                        raise_err(dcount);
                PH_LEN:
                begin
                    if (is_digit(b))
                    begin
                        // length saturates just above 32 bits
                        if (acc <= 64'h0000_0000_FFFF_FFFF)
                        begin
                            acc = acc * 10 + d;
                            if (acc > 64'h0000_0000_FFFF_FFFF)
                                acc = 64'h0000_0001_0000_0000;
                        end
                    end
                    else if (b == CH_COLON)
                    begin
                        if (acc > 64'h0000_0000_FFFF_FFFF)
                            raise_err(ERR_LEN_TOO_BIG);
                        else
                        begin
                            ev.kind  = EV_STR_START;
                            ev.num   = acc;
                            ev.key   = key_wanted();
                            str_left = acc[31:0];
                            if (str_left == 0)
                                value_done();
                            else
                                phase = PH_CONTENT;
                        end
                    end
                    else
                        raise_err(ERR_NO_COLON);
                end
                default:
                begin
                    ev.kind  = EV_STR_BYTE;
                    ev.cbyte = b;
                    ev.key   = key_wanted();
                    str_left--;
                    if (str_left == 0)
                        value_done();
                end
            endcase
        end

        // end marker is looked at after this item's byte
        if (sticky_err == ERR_NONE && e)
        begin
            case (phase)
                PH_FINISHED:
                    ev.ok = 1'b1;
                PH_VALUE:
                    if (sp == 0)
                        raise_err(ERR_EARLY_END);
                    else if (key_wanted())
                        raise_err(ERR_DICT_UNTERM);
                    else if (nest_stack[sp-1][0])
                        raise_err(ERR_EARLY_END);
                    else
                        raise_err(ERR_LIST_UNTERM);
                PH_LEN:
                    raise_err(ERR_NO_COLON);
                PH_CONTENT:
                    raise_err(ERR_STR_PAST_END);
                default:
                    raise_err(ERR_INT_UNTERM);
            endcase
        end

        if (sticky_err != ERR_NONE)
        begin
            ev.kind  = EV_ERROR;
            ev.num   = '0;
            ev.cbyte = '0;
            ev.key   = 1'b0;
            ev.ok    = 1'b0;
        end
        ev.depth = sp[NEST_W-1:0];
        ev.err   = sticky_err;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drive one item at a falling edge and hold it until taken. The
    // expected event is queued right away; it cannot come out before the
    // item is accepted.
    task automatic send_item(input logic [7:0] b, input bit p, input bit e,
                             input bit use_typed, input event_t typed_ev);
        int     gap;
        bit     taken;
        event_t ev;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        byte_value   <= b;
        byte_present <= p;
        end_of_data  <= e;
        tokenize_step(b, p, e, ev);
        expected_events.push_back(use_typed ? typed_ev : ev);
        n_items++;
        if (n_items % 50 == 0)
            quiet = ($urandom_range(0, 3) == 0);
        do
        begin
            @(posedge clk);
            taken = !item_stall;
            @(negedge clk);
        end
        while (!taken);
    endtask

    // One document byte, now and then preceded by an empty item.
    task automatic send_byte(input logic [7:0] b, input bit e);
        if ($urandom_range(0, 7) == 0)
            send_item($urandom_range(0, 255), 1'b0, 1'b0, 1'b0, '0);
        send_item(b, 1'b1, e, 1'b0, '0);
        n_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic add_row(input logic [7:0] b, input bit p, input bit e, input bit typed,
                           input logic [2:0] kind, input longint num, input logic [7:0] cb,
                           input int depth, input bit key);
        dir_row_t r;
        r.b     = b;
        r.p     = p;
        r.e     = e;
        r.typed = typed;
        r.kind  = kind;
        r.num   = num;
        r.cb    = cb;
        r.depth = depth;
        r.key   = key;
        dir_rows.push_back(r);
    endtask

    task automatic emit_int(input longint v);
        send_byte(CH_I, 1'b0);
        send_text($sformatf("%0d", v));
        send_byte(CH_E, 1'b0);
    endtask

    task automatic emit_random_int();
        longint v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1, 2, 3, 4:
                     v = longint'($urandom_range(0, 2000)) - 1000;
            5, 6, 7: v = longint'({$urandom, $urandom});
            8:       v = 64'sh7FFF_FFFF_FFFF_FFFF;
            default: v = 64'sh8000_0000_0000_0000;
        endcase
        emit_int(v);
    endtask

    // String with random content; the length sometimes carries a leading zero.
    task automatic emit_string();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0)
            send_byte(CH_ZERO, 1'b0);
        send_text($sformatf("%0d", len));
        send_byte(CH_COLON, 1'b0);
        repeat (len) send_byte($urandom_range(0, 255), 1'b0);
    endtask

    // Well-formed value of random shape; nesting is kept shallow except for
    // the occasional dive to the full stack depth.
    task automatic gen_value(input int lvl);
        int pick;
        int n;
        pick = (lvl >= 4) ? $urandom_range(0, 69) : $urandom_range(0, 99);
        if (pick < 35)
            emit_random_int();
        else if (pick < 70)
            emit_string();
        else if (pick < 85)
        begin
            send_byte(CH_L, 1'b0);
            repeat ($urandom_range(0, 3)) gen_value(lvl + 1);
            send_byte(CH_E, 1'b0);
        end
        else if (pick < 98)
        begin
            send_byte(CH_D, 1'b0);
            repeat ($urandom_range(0, 3))
            begin
                emit_string();
                gen_value(lvl + 1);
            end
            send_byte(CH_E, 1'b0);
        end
        else
        begin
            n = MAX_DEPTH - sp;
            repeat (n) send_byte(CH_L, 1'b0);
            emit_random_int();
            repeat (n) send_byte(CH_E, 1'b0);
        end
    endtask

    // Close the top list cleanly, or break the document in one chosen way.
    // Either way a few more items follow to exercise the sticky state.
    task automatic finish_document();
        ending_case = $urandom_range(0, 22);
        if (ending_case > ERR_LEN_TOO_BIG)
            ending_case = ERR_NONE;
        case (ending_case)
            ERR_NONE:
            begin
                if ($urandom_range(0, 1))
                    send_byte(CH_E, 1'b1);        // close and end in one item
                else
                begin
                    send_byte(CH_E, 1'b0);
                    send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
                end
                send_item($urandom_range(0, 255), 1'b0, 1'b1, 1'b0, '0);  // end again
            end
            ERR_EARLY_END:
            begin
                send_text("d1:a");
                send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
            end
            ERR_BAD_CHAR:      send_text("x");
            ERR_INT_UNTERM:
            begin
                send_text("i12");
                send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
            end
            ERR_INT_EMPTY:     send_text("ie");
            ERR_NEG_ZERO:      send_text("i-0e");
            ERR_LEAD_ZERO:     send_text("i01e");
            ERR_NEG_LEAD_ZERO: send_text("i-01e");
            ERR_INT_BAD:       send_text("i9223372036854775808e");
            ERR_NO_COLON:      send_text("3x");
            ERR_STR_PAST_END:
            begin
                send_text("5:ab");
                send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
            end
            ERR_KEY_NOT_STR:   send_text("di");
            ERR_LIST_UNTERM:   send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
            ERR_DICT_UNTERM:   send_byte(CH_D, 1'b1);  // open and end together
            ERR_TRAILING:      send_text("ex");
            ERR_TOO_DEEP:      repeat (MAX_DEPTH - sp + 1) send_byte(CH_L, 1'b0);
            default:           send_text("4294967296:");
        endcase
        repeat (6)
            send_item($urandom_range(0, 255), $urandom_range(0, 1),
                      $urandom_range(0, 1), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall a random number of cycles per event
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        event_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 9);
            if (n > 0)
            begin
                event_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            event_stall <= 1'b0;
            do
                @(posedge clk);
            while (!event_valid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (got !== want)
        begin
            $display("MISMATCH at event %0d: %s got %0h, want %0h", n_events, what, got, want);
            n_mismatch++;
        end
    endtask

    always @(posedge clk)
    begin
        event_t want;
        if (rst_n && event_valid && !event_stall)
        begin
            n_events++;
            if (nest_depth > deepest)
                deepest = nest_depth;
            if (expected_events.size() == 0)
                report_mismatch("unexpected event, kind", event_kind, ~64'd0);
            else
            begin
                want = expected_events.pop_front();
                report_mismatch("event_kind",   event_kind,   want.kind);
                report_mismatch("number_value", number_value, want.num);
                report_mismatch("content_byte", content_byte, want.cbyte);
                report_mismatch("nest_depth",   nest_depth,   want.depth);
                report_mismatch("is_key",       is_key,       want.key);
                report_mismatch("error_code",   error_code,   want.err);
                report_mismatch("document_ok",  document_ok,  want.ok);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        event_t typed_ev;
        int     waited;
        item_valid   = 1'b0;
        byte_value   = 8'h00;
        byte_present = 1'b0;
        end_of_data  = 1'b0;
        rst_n        = 1'b0;
        n_mismatch   = 0;
        n_events     = 0;
        n_items      = 0;
        n_bytes      = 0;
        deepest      = 0;
        quiet        = 1'b0;
        ending_case  = ERR_NONE;

        phase      = PH_VALUE;
        acc        = '0;
        neg        = 1'b0;
        dcount     = '0;
        str_left   = '0;
        sp         = 0;
        sticky_err = ERR_NONE;
        foreach (nest_stack[i])
            nest_stack[i] = K_LIST;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: open a top-level list and walk the basic token
        // types inside it: empty item right after reset, list and dict opens,
        // a one-byte key with an all-ones byte, a negative integer, an empty
        // key, a nested list value, a zero integer, an all-zeros content
        // byte, and both closes.
        //       byte       p  e  typ kind          num  cb     dep key
        add_row(8'h00,      0, 0, 1, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_L,       1, 0, 1, EV_LIST_OPEN,  0,   8'h00, 1, 0);
        add_row(CH_D,       1, 0, 1, EV_DICT_OPEN,  0,   8'h00, 2, 0);
        add_row("1",        1, 0, 1, EV_NONE,       0,   8'h00, 2, 0);
        add_row(CH_COLON,   1, 0, 1, EV_STR_START,  1,   8'h00, 2, 1);
        add_row(8'hFF,      1, 0, 1, EV_STR_BYTE,   0,   8'hFF, 2, 1);
        add_row(CH_I,       1, 0, 1, EV_NONE,       0,   8'h00, 2, 0);
        add_row(CH_MINUS,   1, 0, 1, EV_NONE,       0,   8'h00, 2, 0);
        add_row("7",        1, 0, 1, EV_NONE,       0,   8'h00, 2, 0);
        add_row(CH_E,       1, 0, 1, EV_INT,        -7,  8'h00, 2, 0);
        add_row(8'hA5,      0, 0, 1, EV_NONE,       0,   8'h00, 2, 0);
        add_row(CH_ZERO,    1, 0, 1, EV_NONE,       0,   8'h00, 2, 0);
        add_row(CH_COLON,   1, 0, 1, EV_STR_START,  0,   8'h00, 2, 1);
        add_row(CH_L,       1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_I,       1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_ZERO,    1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_E,       1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row("1",        1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_COLON,   1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(8'h00,      1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_E,       1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);
        add_row(CH_E,       1, 0, 0, EV_NONE,       0,   8'h00, 0, 0);

        foreach (dir_rows[i])
        begin
            typed_ev       = '0;
            typed_ev.kind  = dir_rows[i].kind;
            typed_ev.num   = dir_rows[i].num;
            typed_ev.cbyte = dir_rows[i].cb;
            typed_ev.depth = dir_rows[i].depth;
            typed_ev.key   = dir_rows[i].key;
            typed_ev.err   = ERR_NONE;
            typed_ev.ok    = 1'b0;
            send_item(dir_rows[i].b, dir_rows[i].p, dir_rows[i].e,
                      dir_rows[i].typed, typed_ev);
        end

        // Random part: the top list keeps growing with random values; both
        // integer extremes go in first.
        emit_int(64'sh7FFF_FFFF_FFFF_FFFF);
        emit_int(64'sh8000_0000_0000_0000);
        while (n_bytes < BYTE_TARGET)
            gen_value(1);
        finish_document();
        item_valid <= 1'b0;

        // Drain, then a few settle cycles to catch stray events.
        waited = 0;
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $display("MISMATCH: %0d expected events never arrived", expected_events.size());
            n_mismatch++;
        end

        $display("Sent %0d items (%0d document bytes), checked %0d events, deepest nesting %0d.",
                 n_items, n_bytes, n_events, deepest);
        $display("Document ending exercised error code %0d (0 = clean close).", ending_case);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout: run did not complete");
        $display("Mismatches found");
        $finish;
    end

endmodule
